>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion forms for the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, inactive while reset is asserted
`define CHK_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, inactive while reset is asserted
`define CHK_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

// Condition that must hold in the cycle after reset is sampled low
`define CHK_AFTER_RESET(label, clk, rstn, cons) \
    label: assert property (@(posedge clk) !(rstn) |=> (cons)) \
        else $error("assertion failed: state after reset");

`endif

>>> design/sobel_pkg.sv
// ----------------------------------------------------------------------------
// Sobel package
// Field widths, register indexes, queue entry types and the square-root step.
// ----------------------------------------------------------------------------
package sobel_pkg;

    localparam int PIX_W    = 8;
    localparam int COL_W    = 10;
    localparam int ROW_W    = 12;
    localparam int WREG_W   = 11;
    localparam int HREG_W   = 13;
    localparam int CFG_W    = 13;
    localparam int GRAD_W   = 9;
    localparam int SUM_W    = 17;
    localparam int RAD_W    = 16;
    localparam int REM_W    = 9;
    localparam int ROOT_W   = 8;
    localparam int SQ_STEPS = 8;
    localparam int QDEPTH   = 8;
    localparam int QPTR_W   = 3;
    localparam int QCNT_W   = 4;

    localparam logic [0:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [0:0] REG_IMAGE_HEIGHT = 1'b1;

    localparam logic [WREG_W-1:0] WIDTH_RESET  = 11'd640;
    localparam logic [HREG_W-1:0] HEIGHT_RESET = 13'd480;
    localparam logic [HREG_W-1:0] HEIGHT_MAX   = 13'd4096;

    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             last;
    } meta_t;

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        meta_t            meta;
    } entry_t;

    typedef struct packed {
        logic [RAD_W-1:0]  rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } sq_t;

    // One digit of a restoring square root: two radicand bits in, one root bit out
    function automatic sq_t sqrt_step(sq_t cur);
        sq_t               nxt;
        logic [REM_W+1:0]  rem_sh;
        logic [REM_W+1:0]  trial;
        logic [REM_W+1:0]  diff;
        rem_sh = {cur.rem, cur.rad[RAD_W-1 -: 2]};
        trial  = {1'b0, cur.root, 2'b01};
        diff   = rem_sh - trial;
        nxt.rad = {cur.rad[RAD_W-3:0], 2'b00};
        if (rem_sh >= trial) begin
            nxt.rem  = diff[REM_W-1:0];
            nxt.root = {cur.root[ROOT_W-2:0], 1'b1};
        end else begin
            nxt.rem  = rem_sh[REM_W-1:0];
            nxt.root = {cur.root[ROOT_W-2:0], 1'b0};
        end
        return nxt;
    endfunction

endpackage

>>> design/sobel_edge_magnitude_3x3.sv
// Throughput: one pixel per cycle while s_ready is high.
// The front pipe is three stages, the root pipe eight.
// s_ready falls when the 8-entry result queue plus the front pipe could overflow.
// Reset: aresetn synchronous, active low; clears position, window, queue, valid bits,
// and sets image_width to 640, image_height to 480. Line stores are not cleared.
// ----------------------------------------------------------------------------
// Sobel edge magnitude, 3x3
// Raster pixel stream in, saturated Sobel magnitude per interior pixel out.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude_3x3 #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [0:0]                    cfg_index,
    input  logic [sobel_pkg::CFG_W-1:0]   cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [sobel_pkg::PIX_W-1:0]   s_pixel_value,
    input  logic                          s_frame_first,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [sobel_pkg::PIX_W-1:0]   m_edge_magnitude,
    output logic [sobel_pkg::COL_W-1:0]   m_centre_column,
    output logic [sobel_pkg::ROW_W-1:0]   m_centre_row,
    output logic                          m_frame_last
);
    import sobel_pkg::*;

    logic                q_push, q_pop, q_not_empty;
    entry_t              q_in, q_head;
    logic [QCNT_W-1:0]   q_count;

    sobel_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_pixel_value (s_pixel_value),
        .s_frame_first (s_frame_first),
        .q_count       (q_count),
        .q_push        (q_push),
        .q_entry       (q_in)
    );

    sobel_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_in),
        .pop        (q_pop),
        .head       (q_head),
        .not_empty  (q_not_empty),
        .count      (q_count)
    );

    sobel_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .q_head           (q_head),
        .q_not_empty      (q_not_empty),
        .q_pop            (q_pop),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_edge_magnitude (m_edge_magnitude),
        .m_centre_column  (m_centre_column),
        .m_centre_row     (m_centre_row),
        .m_frame_last     (m_frame_last)
    );

endmodule

>>> design/sobel_front.sv
// ----------------------------------------------------------------------------
// Sobel front end
// Accepts pixels, tracks position, keeps the line stores and the 3x3 window,
// forms both gradients and their squared sum, and pushes results to the queue.
// ----------------------------------------------------------------------------
module sobel_front #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [0:0]                    cfg_index,
    input  logic [sobel_pkg::CFG_W-1:0]   cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [sobel_pkg::PIX_W-1:0]   s_pixel_value,
    input  logic                          s_frame_first,
    input  logic [sobel_pkg::QCNT_W-1:0]  q_count,
    output logic                          q_push,
    output sobel_pkg::entry_t             q_entry
);
    import sobel_pkg::*;

    localparam int AW   = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
    localparam int WCAP = (MAX_WIDTH < 2047) ? MAX_WIDTH : 2047;

    function automatic logic signed [10:0] ext(logic [PIX_W-1:0] p);
        return $signed({3'b000, p});
    endfunction

    logic [WREG_W-1:0] width_reg;
    logic [HREG_W-1:0] height_reg;
    logic [WREG_W-1:0] w_eff;
    logic [HREG_W-1:0] h_eff;

    logic [COL_W-1:0]  col_reg, col_next, col_cur;
    logic [ROW_W-1:0]  row_reg, row_next, row_cur;
    logic [WREG_W-1:0] col_inc;
    logic [HREG_W-1:0] row_inc;
    logic              col_wrap, row_wrap;
    logic              accept;
    logic [AW-1:0]     addr;
    meta_t             meta_cur;
    logic              prod_cur;

    logic [PIX_W-1:0]  line_upper_reg  [MAX_WIDTH];
    logic [PIX_W-1:0]  line_middle_reg [MAX_WIDTH];

    logic              v1_reg, v2_reg, v3_reg;
    logic [AW-1:0]     addr1_reg;
    logic [PIX_W-1:0]  pix1_reg;
    logic [PIX_W-1:0]  up_rd_reg, mid_rd_reg;
    logic              prod1_reg, prod2_reg, prod3_reg;
    meta_t             meta1_reg, meta2_reg, meta3_reg;
    logic [PIX_W-1:0]  win_reg [9];

    logic signed [10:0]       gx_full, gy_full;
    logic signed [GRAD_W-1:0] gx3_reg, gy3_reg;
    logic signed [2*GRAD_W-1:0] sq_x, sq_y;
    logic [QCNT_W:0]          occupancy;

    // Configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:  width_reg  <= cfg_wdata[WREG_W-1:0];
                REG_IMAGE_HEIGHT: height_reg <= cfg_wdata[HREG_W-1:0];
            endcase
        end
    end

    always_comb begin
        priority if (width_reg < 11'd3) begin
            w_eff = 11'd3;
        end else if (width_reg > WREG_W'(WCAP)) begin
            w_eff = WREG_W'(WCAP);
        end else begin
            w_eff = width_reg;
        end
        priority if (height_reg < 13'd3) begin
            h_eff = 13'd3;
        end else if (height_reg > HEIGHT_MAX) begin
            h_eff = HEIGHT_MAX;
        end else begin
            h_eff = height_reg;
        end
    end

    // Position tracking
    assign occupancy = (QCNT_W+1)'(q_count) + (QCNT_W+1)'(v1_reg)
                     + (QCNT_W+1)'(v2_reg) + (QCNT_W+1)'(v3_reg);
    assign s_ready   = occupancy < (QCNT_W+1)'(QDEPTH);
    assign accept    = s_valid && s_ready;

    assign col_cur  = s_frame_first ? '0 : col_reg;
    assign row_cur  = s_frame_first ? '0 : row_reg;
    assign col_inc  = {1'b0, col_cur} + 11'd1;
    assign row_inc  = {1'b0, row_cur} + 13'd1;
    assign col_wrap = col_inc >= w_eff;
    assign row_wrap = row_inc >= h_eff;
    assign col_next = col_wrap ? '0 : col_inc[COL_W-1:0];
    assign row_next = col_wrap ? (row_wrap ? '0 : row_inc[ROW_W-1:0]) : row_cur;

    assign prod_cur      = (col_cur >= 10'd2) && (row_cur >= 12'd2);
    assign meta_cur.col  = col_cur - 10'd1;
    assign meta_cur.row  = row_cur - 12'd1;
    assign meta_cur.last = col_wrap && row_wrap;
    assign addr          = AW'(col_cur);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (accept) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Line stores: read both on accept, write the upper one in the cycle after
    always_ff @(posedge aclk) begin
        if (accept) begin
            mid_rd_reg             <= line_middle_reg[addr];
            line_middle_reg[addr]  <= s_pixel_value;
            // forward a write still in flight to the same column
            if (v1_reg && addr1_reg == addr) begin
                up_rd_reg <= mid_rd_reg;
            end else begin
                up_rd_reg <= line_upper_reg[addr];
            end
        end
        if (v1_reg) begin
            line_upper_reg[addr1_reg] <= mid_rd_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= accept;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            addr1_reg <= addr;
            pix1_reg  <= s_pixel_value;
            prod1_reg <= prod_cur;
            meta1_reg <= meta_cur;
        end
        prod2_reg <= prod1_reg;
        meta2_reg <= meta1_reg;
        prod3_reg <= prod2_reg;
        meta3_reg <= meta2_reg;
        gx3_reg   <= gx_full[10:2];
        gy3_reg   <= gy_full[10:2];
    end

    // Window: advance one column per item, newest column on the right
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < 9; k++) begin
                win_reg[k] <= '0;
            end
        end else if (v1_reg) begin
            for (int k = 0; k < 3; k++) begin
                win_reg[k*3]   <= win_reg[k*3+1];
                win_reg[k*3+1] <= win_reg[k*3+2];
            end
            win_reg[2] <= up_rd_reg;
            win_reg[5] <= mid_rd_reg;
            win_reg[8] <= pix1_reg;
        end
    end

    assign gx_full = ext(win_reg[0]) - ext(win_reg[2])
                   + (ext(win_reg[3]) <<< 1) - (ext(win_reg[5]) <<< 1)
                   + ext(win_reg[6]) - ext(win_reg[8]);
    assign gy_full = ext(win_reg[6]) + (ext(win_reg[7]) <<< 1) + ext(win_reg[8])
                   - ext(win_reg[0]) - (ext(win_reg[1]) <<< 1) - ext(win_reg[2]);

    assign sq_x = gx3_reg * gx3_reg;
    assign sq_y = gy3_reg * gy3_reg;

    assign q_push        = v3_reg && prod3_reg;
    assign q_entry.sum   = SUM_W'(sq_x[RAD_W-1:0]) + SUM_W'(sq_y[RAD_W-1:0]);
    assign q_entry.meta  = meta3_reg;

endmodule

>>> design/sobel_queue.sv
// ----------------------------------------------------------------------------
// Sobel result queue
// Short FIFO between the front end and the square-root back end.
// ----------------------------------------------------------------------------
module sobel_queue (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          push,
    input  sobel_pkg::entry_t             push_entry,
    input  logic                          pop,
    output sobel_pkg::entry_t             head,
    output logic                          not_empty,
    output logic [sobel_pkg::QCNT_W-1:0]  count
);
    import sobel_pkg::*;

    entry_t              buf_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic                do_pop;

    assign do_pop    = pop && (count_reg != '0);
    assign not_empty = count_reg != '0;
    assign count     = count_reg;
    assign head      = buf_reg[rd_ptr_reg];

    always_comb begin
        unique case ({push, do_pop})
            2'b10:   count_next = count_reg + 4'd1;
            2'b01:   count_next = count_reg - 4'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 3'd1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 3'd1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            buf_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

>>> design/sobel_back.sv
// ----------------------------------------------------------------------------
// Sobel back end
// Pipelined digit-by-digit square root, one root bit per stage; the last
// stage is the output register.
// ----------------------------------------------------------------------------
module sobel_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  sobel_pkg::entry_t             q_head,
    input  logic                          q_not_empty,
    output logic                          q_pop,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [sobel_pkg::PIX_W-1:0]   m_edge_magnitude,
    output logic [sobel_pkg::COL_W-1:0]   m_centre_column,
    output logic [sobel_pkg::ROW_W-1:0]   m_centre_row,
    output logic                          m_frame_last
);
    import sobel_pkg::*;

    localparam int LAST = SQ_STEPS - 1;

    sq_t                 sq_reg   [SQ_STEPS];
    meta_t               meta_reg [SQ_STEPS];
    logic [SQ_STEPS-1:0] bv_reg;
    logic                advance;
    sq_t                 sq_init;

    // hold the whole pipe while the output item waits
    assign advance = !bv_reg[LAST] || m_ready;
    assign q_pop   = advance && q_not_empty;

    // sums of 2^16 and above saturate: the root of all ones is the top value
    assign sq_init.rad  = q_head.sum[SUM_W-1] ? '1 : q_head.sum[RAD_W-1:0];
    assign sq_init.rem  = '0;
    assign sq_init.root = '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bv_reg <= '0;
        end else if (advance) begin
            bv_reg <= {bv_reg[SQ_STEPS-2:0], q_pop};
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            sq_reg[0]   <= sqrt_step(sq_init);
            meta_reg[0] <= q_head.meta;
            for (int k = 1; k < SQ_STEPS; k++) begin
                sq_reg[k]   <= sqrt_step(sq_reg[k-1]);
                meta_reg[k] <= meta_reg[k-1];
            end
        end
    end

    assign m_valid          = bv_reg[LAST];
    assign m_edge_magnitude = sq_reg[LAST].root;
    assign m_centre_column  = meta_reg[LAST].col;
    assign m_centre_row     = meta_reg[LAST].row;
    assign m_frame_last     = meta_reg[LAST].last;

endmodule

>>> design/sobel_checker.sv
// ----------------------------------------------------------------------------
// Sobel port checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sobel_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [7:0]  m_edge_magnitude,
    input logic [9:0]  m_centre_column,
    input logic [11:0] m_centre_row,
    input logic        m_frame_last
);

    // a waiting item holds its payload
    `CHK_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable({m_edge_magnitude, m_centre_column, m_centre_row, m_frame_last}))

    // results only come from interior pixels
    `CHK_IMPLY(a_interior, aclk, aresetn, m_valid, (m_centre_column != 10'd0) && (m_centre_row != 12'd0))

    // reset empties the result pipe
    `CHK_AFTER_RESET(a_reset_empty, aclk, aresetn, !m_valid)

endmodule

bind sobel_edge_magnitude_3x3 sobel_checker u_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_edge_magnitude (m_edge_magnitude),
    .m_centre_column  (m_centre_column),
    .m_centre_row     (m_centre_row),
    .m_frame_last     (m_frame_last)
);

>>> tb/sv/sobel_edge_magnitude_3x3_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sobel edge magnitude testbench
// Streams raster pixels through the block under random source gaps and sink
// stalls. Results of a few hand-made 3x3 frames are checked against a table,
// the rest against an in-bench edge predictor: clamped, wrapped and shrunk
// image shapes, a wide frame, and random phases of mixed image sizes.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude_3x3_tb;
    import sobel_pkg::*;

    localparam int LINE_DEPTH    = 1024;
    localparam int STALL_LIMIT   = 1000;
    localparam int RANDOM_ITEMS  = 560;
    localparam int WIDE_LINE     = 160;
    localparam int SETTLE_CYCLES = 24;
    localparam int DRAIN_CYCLES  = 40;

    typedef struct packed {
        logic [PIX_W-1:0] magnitude;
        logic [COL_W-1:0] column;
        logic [ROW_W-1:0] row;
        logic             frame_last;
    } edge_result_t;

    typedef struct packed {
        logic [9*PIX_W-1:0] pixels;
        logic               first;
        logic [PIX_W-1:0]   magnitude;
    } frame_row_t;

    logic              aclk;
    logic              aresetn;
    logic              cfg_wr_en;
    logic [0:0]        cfg_index;
    logic [CFG_W-1:0]  cfg_wdata;
    logic              s_valid;
    logic              s_ready;
    logic [PIX_W-1:0]  s_pixel_value;
    logic              s_frame_first;
    logic              m_valid;
    logic              m_ready;
    logic [PIX_W-1:0]  m_edge_magnitude;
    logic [COL_W-1:0]  m_centre_column;
    logic [ROW_W-1:0]  m_centre_row;
    logic              m_frame_last;

    // Predictor state
    logic [WREG_W-1:0] width_reg;
    logic [HREG_W-1:0] height_reg;
    logic [PIX_W-1:0]  upper_line [0:LINE_DEPTH-1];
    logic [PIX_W-1:0]  middle_line [0:LINE_DEPTH-1];
    logic [PIX_W-1:0]  window [0:8];
    int                col_pos;
    int                row_pos;

    edge_result_t      pending_edges [$];
    frame_row_t        frame_table [0:2];
    int                mismatches = 0;
    int                quiet_cycles = 0;
    bit                src_idle_on = 1'b1;
    bit                sink_idle_on = 1'b1;

    sobel_edge_magnitude_3x3 DUT (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_pixel_value    (s_pixel_value),
        .s_frame_first    (s_frame_first),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_edge_magnitude (m_edge_magnitude),
        .m_centre_column  (m_centre_column),
        .m_centre_row     (m_centre_row),
        .m_frame_last     (m_frame_last)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic int clamp_width(input logic [WREG_W-1:0] v);
        if (v < 3) return 3;
        if (v > LINE_DEPTH) return LINE_DEPTH;
        return int'(v);
    endfunction

    // Advance the line stores and window by one pixel; report the edge result if any
    function automatic bit predict_edge(input logic [PIX_W-1:0] pix, input logic first,
                                        output edge_result_t res);
        int               w, h, c, r, gx, gy, sum, root, k;
        int               p [0:8];
        logic [PIX_W-1:0] up, mid;
        bit               produced;
        w = clamp_width(width_reg);
        h = int'(height_reg);
        if (h < 3) h = 3;
        if (h > 4096) h = 4096;
        if (first) begin
            col_pos = 0;
            row_pos = 0;
        end
        c = col_pos;
        r = row_pos;
        up  = upper_line[c];
        mid = middle_line[c];
        upper_line[c]  = mid;
        middle_line[c] = pix;
        for (k = 0; k < 3; k++) begin
            window[k*3]     = window[k*3 + 1];
            window[k*3 + 1] = window[k*3 + 2];
        end
        window[2] = up;
        window[5] = mid;
        window[8] = pix;
        produced = (c >= 2 && r >= 2);
        res = '0;
        if (produced) begin
            for (k = 0; k < 9; k++) p[k] = int'(window[k]);
            gx = p[0] - p[2] + 2*p[3] - 2*p[5] + p[6] - p[8];
            gy = -p[0] - 2*p[1] - p[2] + p[6] + 2*p[7] + p[8];
            gx = gx >>> 2;
            gy = gy >>> 2;
            sum = gx*gx + gy*gy;
            // floor square root, stopping at the saturation value
            root = 0;
            while (root < 255 && (root + 1) * (root + 1) <= sum) root++;
            res.magnitude  = root[PIX_W-1:0];
            res.column     = COL_W'(c - 1);
            res.row        = ROW_W'(r - 1);
            res.frame_last = (c + 1 >= w) && (r + 1 >= h);
        end
        c++;
        if (c >= w) begin
            c = 0;
            r++;
            if (r >= h) r = 0;
        end
        col_pos = c % LINE_DEPTH;
        row_pos = r % 4096;
        return produced;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance
    task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic first,
                              input bit use_typed, input edge_result_t typed);
        int           gap;
        bit           produced;
        edge_result_t predicted;
        gap = src_idle_on ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid       = 1'b1;
        s_pixel_value = pix;
        s_frame_first = first;
        @(posedge aclk);
        while (s_ready !== 1'b1) @(posedge aclk);
        produced = predict_edge(pix, first, predicted);
        if (produced) pending_edges.push_back(use_typed ? typed : predicted);
        @(negedge aclk);
    endtask

    task automatic write_register(input logic [0:0] idx, input logic [CFG_W-1:0] value);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = value;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        if (idx == REG_IMAGE_WIDTH) width_reg = value[WREG_W-1:0];
        else height_reg = value[HREG_W-1:0];
    endtask

    // Drain the block, let border pixels leave the pipe, then write both registers
    task automatic reconfigure(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
        s_valid = 1'b0;
        while (pending_edges.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
        write_register(REG_IMAGE_WIDTH, w);
        write_register(REG_IMAGE_HEIGHT, h);
    endtask

    task automatic run_frames(input int count, input bit restart, input bit noise);
        logic [PIX_W-1:0] pix, step;
        logic             first;
        int               pick, n;
        pix = 8'd128;
        for (n = 0; n < count; n++) begin
            pick = $urandom_range(0, 9);
            step = PIX_W'($urandom_range(0, 6));
            if (pick < 5) pix = PIX_W'($urandom_range(0, 255));
            else if (pick < 7) pix = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            else pix = pix + step - 8'd3;
            first = (n == 0) ? restart : (noise && $urandom_range(0, 49) == 0);
            send_pixel(pix, first, 1'b0, '0);
        end
    endtask

    initial begin : stimulus
        edge_result_t      typed;
        logic [CFG_W-1:0]  new_w, new_h;
        int                i, k, sel, count, random_sent;
        bit                carry_on;

        aresetn       = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_index     = REG_IMAGE_WIDTH;
        cfg_wdata     = '0;
        s_valid       = 1'b0;
        s_pixel_value = '0;
        s_frame_first = 1'b0;
        width_reg     = WIDTH_RESET;
        height_reg    = HEIGHT_RESET;
        col_pos       = 0;
        row_pos       = 0;
        for (i = 0; i < LINE_DEPTH; i++) begin
            upper_line[i]  = '0;
            middle_line[i] = '0;
        end
        for (i = 0; i < 9; i++) window[i] = '0;

        // 3x3 frames, pixel 0 in the low byte; {pixels, frame_first, magnitude}
        frame_table[0] = {72'h00_00_00_00_00_00_00_00_00, 1'b1, 8'd0};   // flat image
        frame_table[1] = {72'h00_00_FF_00_00_FF_00_00_FF, 1'b0, 8'd255}; // bright left column
        frame_table[2] = {72'hFF_00_00_FF_00_00_FF_FF_FF, 1'b1, 8'd255}; // corner, saturates

        repeat (12) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Both registers below range clamp to a 3x3 image
        reconfigure(13'd0, 13'd0);
        for (i = 0; i < 3; i++) begin
            typed.magnitude  = frame_table[i].magnitude;
            typed.column     = 10'd1;
            typed.row        = 12'd1;
            typed.frame_last = 1'b1;
            for (k = 0; k < 9; k++)
                send_pixel(frame_table[i].pixels[k*PIX_W +: PIX_W],
                           (k == 0) && frame_table[i].first, k == 8, typed);
        end

        // Tall image, then shrink the height below the current row
        reconfigure(13'd3, 13'd8191);
        run_frames(60, 1'b1, 1'b0);
        reconfigure(13'd0, 13'd5);
        run_frames(30, 1'b0, 1'b0);

        // Stop mid-row, then shrink the width below the current column
        reconfigure(13'd12, 13'd6);
        run_frames(41, 1'b1, 1'b0);
        reconfigure(13'd4, 13'd6);
        run_frames(30, 1'b0, 1'b1);

        // One full frame on a wide line
        reconfigure(CFG_W'(WIDE_LINE), 13'd4);
        run_frames(4 * WIDE_LINE, 1'b1, 1'b0);

        random_sent = 0;
        while (random_sent < RANDOM_ITEMS) begin
            sel = $urandom_range(0, 9);
            if (sel < 7) new_w = CFG_W'($urandom_range(3, 12));
            else if (sel < 8) new_w = CFG_W'($urandom_range(0, 2));
            else new_w = CFG_W'($urandom_range(13, 40));
            sel = $urandom_range(0, 9);
            if (sel < 6) new_h = CFG_W'($urandom_range(3, 8));
            else if (sel < 7) new_h = CFG_W'($urandom_range(0, 2));
            else if (sel < 9) new_h = CFG_W'($urandom_range(9, 64));
            else new_h = CFG_W'($urandom_range(4096, 8191));
            // keep the frame going only if no line grows past what was stored
            carry_on = (clamp_width(new_w[WREG_W-1:0]) <= clamp_width(width_reg))
                       && ($urandom_range(0, 3) == 0);
            reconfigure(new_w, new_h);
            src_idle_on  = $urandom_range(0, 3) != 0;
            sink_idle_on = $urandom_range(0, 3) != 0;
            count = $urandom_range(40, 160);
            run_frames(count, !carry_on, 1'b1);
            random_sent += count;
        end

        s_valid = 1'b0;
        while (pending_edges.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (mismatches == 0) begin
            $display("sobel_edge_magnitude_3x3_tb passed");
        end else begin
            $display("sobel_edge_magnitude_3x3_tb failed");
        end
        $finish;
    end

    initial begin : result_sink
        int           stall;
        edge_result_t seen, want;
        m_ready = 1'b0;
        forever begin
            stall = sink_idle_on ? $urandom_range(0, 7) : 0;
            if (stall > 0) begin
                m_ready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready = 1'b1;
            @(posedge aclk);
            while (!(aresetn === 1'b1 && m_valid === 1'b1)) @(posedge aclk);
            seen = {m_edge_magnitude, m_centre_column, m_centre_row, m_frame_last};
            if (pending_edges.size() == 0) begin
                $display("%0t: unexpected item: magnitude %0d column %0d row %0d last %0b",
                         $time, seen.magnitude, seen.column, seen.row, seen.frame_last);
                mismatches++;
            end else begin
                want = pending_edges.pop_front();
                if (seen !== want) begin
                    $display("%0t: expected magnitude %0d column %0d row %0d last %0b",
                             $time, want.magnitude, want.column, want.row, want.frame_last);
                    $display("%0t: actual   magnitude %0d column %0d row %0d last %0b",
                             $time, seen.magnitude, seen.column, seen.row, seen.frame_last);
                    mismatches++;
                end
            end
            @(negedge aclk);
        end
    end

    // Abort when neither channel has moved an item for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $time, quiet_cycles);
            $display("sobel_edge_magnitude_3x3_tb failed");
            $finish;
        end
    end

endmodule
